@@ src/c2p_pkg.sv @@
// Shared types, constants and the arctangent table for the Cartesian-to-polar converter.
package c2p_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int ITERATIONS_DEF = 16;
  localparam int GUARD_BITS     = 16;
  localparam int XY_W           = DATA_WIDTH + GUARD_BITS + 3;
  localparam int Z_W            = 32;
  localparam int GAIN_W         = 32;
  localparam int ATAN_ENTRIES   = 32;
  localparam int ANG_SHIFT      = Z_W - DATA_WIDTH;
  localparam int MUL_LO_W       = (XY_W - 1) / 2;
  localparam int MUL_HI_W       = XY_W - 1 - MUL_LO_W;
  localparam int PROD_W         = MUL_HI_W + GAIN_W;
  localparam int SUM_W          = XY_W + GAIN_W;
  localparam int MAG_SHIFT      = GAIN_W + GUARD_BITS;
  localparam int MAG_FULL_W     = SUM_W - MAG_SHIFT;

  localparam logic [GAIN_W-1:0] INV_GAIN = 32'd2608131496;
  localparam logic [Z_W-1:0]    Z_PI     = 32'h8000_0000;

  typedef logic [Z_W-1:0] atan_tab_t [ATAN_ENTRIES];

  localparam atan_tab_t ATAN_TABLE = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_coord;
    logic signed [DATA_WIDTH-1:0] y_coord;
  } c2p_in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0]        magnitude;
    logic signed [DATA_WIDTH-1:0] angle;
  } c2p_out_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [Z_W-1:0]         z;
    logic                   zero;
  } cell_data_t;

endpackage

@@ src/c2p_prep.sv @@
// Input stage: folds the left half-plane onto the right and scales by the guard bits.
module c2p_prep import c2p_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  c2p_in_t    up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output cell_data_t dn_data
);

  logic                   valid_r;
  cell_data_t             data_r;
  cell_data_t             data_nxt;
  logic signed [XY_W-1:0] xe;
  logic signed [XY_W-1:0] ye;

  always_comb begin
    xe = XY_W'(up_data.x_coord);
    ye = XY_W'(up_data.y_coord);
    if (up_data.x_coord[DATA_WIDTH-1]) begin
      xe = -xe;
      ye = -ye;
      data_nxt.z = Z_PI;
    end else begin
      data_nxt.z = '0;
    end
    data_nxt.x    = xe <<< GUARD_BITS;
    data_nxt.y    = ye <<< GUARD_BITS;
    data_nxt.zero = (up_data.x_coord == '0) && (up_data.y_coord == '0);
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ src/c2p_cell.sv @@
// One CORDIC vectoring micro-rotation with its pipeline register.
module c2p_cell import c2p_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  cell_data_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output cell_data_t dn_data
);

  localparam logic [Z_W-1:0] ATAN_STEP = ATAN_TABLE[STAGE];

  logic                   valid_r;
  cell_data_t             data_r;
  cell_data_t             data_nxt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  always_comb begin
    xs = up_data.x >>> STAGE;
    ys = up_data.y >>> STAGE;
    data_nxt.zero = up_data.zero;
    if (!up_data.y[XY_W-1]) begin
      data_nxt.x = up_data.x + ys;
      data_nxt.y = up_data.y - xs;
      data_nxt.z = up_data.z + ATAN_STEP;
    end else begin
      data_nxt.x = up_data.x - ys;
      data_nxt.y = up_data.y + xs;
      data_nxt.z = up_data.z - ATAN_STEP;
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ src/c2p_comp.sv @@
// Output stages: gain compensation in two partial products, angle rounding and the result register.
module c2p_comp import c2p_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  cell_data_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output c2p_out_t   dn_data
);

  logic                    mv_r;
  logic [PROD_W-1:0]       p_hi_r;
  logic [PROD_W-1:0]       p_lo_r;
  logic                    zero_r;
  logic [DATA_WIDTH-1:0]   ang_r;
  logic                    m_ready;

  logic [XY_W-2:0]         xu;
  logic [Z_W-1:0]          z_rnd;
  logic [DATA_WIDTH-1:0]   ang_nxt;

  logic                    ov_r;
  c2p_out_t                out_r;
  c2p_out_t                out_nxt;
  logic [SUM_W-1:0]        sum;
  logic [MAG_FULL_W-1:0]   mag_full;

  always_comb begin
    xu      = up_data.x[XY_W-1] ? '0 : up_data.x[XY_W-2:0];
    z_rnd   = up_data.z + (Z_W'(1) << (ANG_SHIFT - 1));
    ang_nxt = up_data.zero ? '0 : z_rnd[Z_W-1 -: DATA_WIDTH];
  end

  assign m_ready  = !ov_r || dn_ready;
  assign up_ready = !mv_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (up_ready) begin
      mv_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      p_hi_r <= PROD_W'(xu[XY_W-2:MUL_LO_W]) * PROD_W'(INV_GAIN);
      p_lo_r <= PROD_W'(xu[MUL_LO_W-1:0]) * PROD_W'(INV_GAIN);
      zero_r <= up_data.zero;
      ang_r  <= ang_nxt;
    end
  end

  always_comb begin
    sum = (SUM_W'(p_hi_r) << MUL_LO_W) + SUM_W'(p_lo_r)
        + (SUM_W'(1) << (MAG_SHIFT - 1));
    mag_full = sum[SUM_W-1:MAG_SHIFT];
    if (zero_r) begin
      out_nxt.magnitude = '0;
    end else if (mag_full[MAG_FULL_W-1:DATA_WIDTH] != '0) begin
      out_nxt.magnitude = '1;
    end else begin
      out_nxt.magnitude = mag_full[DATA_WIDTH-1:0];
    end
    out_nxt.angle = ang_r;
  end

  assign dn_valid = ov_r;
  assign dn_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (m_ready) begin
      ov_r <= mv_r;
    end
    if (m_ready && mv_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

@@ src/cartesian_to_polar.sv @@
// Top level of the CORDIC Cartesian-to-polar converter.
//
//   Channel  Ports                       Contents
//   input    in_valid/in_stall/in_data   x_coord, y_coord
//   result   out_valid/out_stall/out_data magnitude, angle
//
// One item enters per cycle while out_stall is low; the stages are one input stage,
// one cell per micro-rotation, then the compensation multiply and the result register.
// Each stage holds a valid bit, so bubbles close up while the result side stalls.
// in_stall rises only when every stage is full and out_stall is high.
// Reset clears the valid bits only; the datapath registers need none.
module cartesian_to_polar import c2p_pkg::*; #(
  parameter int ITERATIONS = ITERATIONS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  c2p_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output c2p_out_t out_data
);

  logic       prep_ready;
  logic       chain_valid [ITERATIONS+1];
  logic       chain_ready [ITERATIONS+1];
  cell_data_t chain_data  [ITERATIONS+1];

  assign in_stall = !prep_ready;

  c2p_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (prep_ready),
    .up_data  (in_data),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    c2p_cell #(.STAGE(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  c2p_comp u_comp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (chain_valid[ITERATIONS]),
    .up_ready (chain_ready[ITERATIONS]),
    .up_data  (chain_data[ITERATIONS]),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_data  (out_data)
  );

endmodule

@@ test/c2p_checker.sv @@
// Checker for the Cartesian-to-polar converter: predicts each result and compares it.
`timescale 1ns / 1ps

module c2p_checker import c2p_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  c2p_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  c2p_out_t out_data,
  output int       errors,
  output int       pending,
  output int       checked
);

  localparam int          ROTATIONS = 16;
  localparam int          FRAC_BITS = 16;
  localparam logic [31:0] GAIN_INV  = 32'd2608131496;
  localparam logic [63:0] HALF_TURN = 64'h0000_0000_8000_0000;

  localparam logic [31:0] ARCTAN [ROTATIONS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  c2p_out_t expected_polar[$];

  function automatic c2p_out_t polar_of(c2p_in_t point);
    longint       x;
    longint       y;
    longint       z;
    longint       xs;
    longint       ys;
    logic [127:0] scaled;
    logic [63:0]  zr;
    c2p_out_t     res;
    x = longint'(point.x_coord);
    y = longint'(point.y_coord);
    z = 0;
    if (x == 0 && y == 0) begin
      return '0;
    end
    // Points in the left half plane are turned by pi first.
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(HALF_TURN);
    end
    x = x <<< FRAC_BITS;
    y = y <<< FRAC_BITS;
    for (int i = 0; i < ROTATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ARCTAN[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ARCTAN[i]);
      end
    end
    if (x < 0) begin
      x = 0;
    end
    scaled = 128'(x) * 128'(GAIN_INV);
    scaled = (scaled + (128'd1 << (31 + FRAC_BITS))) >> (32 + FRAC_BITS);
    res.magnitude = (scaled > 128'h0000_FFFF) ? 16'hFFFF : scaled[15:0];
    zr = 64'(z) + 64'd32768;
    res.angle = zr[31:16];
    return res;
  endfunction

  always @(posedge clk) begin
    c2p_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_polar.size() == 0) begin
          $error("unexpected result: magnitude %0d, angle %0d",
                 out_data.magnitude, out_data.angle);
          errors++;
        end else begin
          want = expected_polar.pop_front();
          checked++;
          if (out_data.magnitude !== want.magnitude) begin
            $error("magnitude mismatch: expected %0d, got %0d",
                   want.magnitude, out_data.magnitude);
            errors++;
          end
          if (out_data.angle !== want.angle) begin
            $error("angle mismatch: expected %0d, got %0d", want.angle, out_data.angle);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_polar.push_back(polar_of(in_data));
      end
    end
    pending = expected_polar.size();
  end

endmodule

@@ test/testbench.sv @@
// Top of the Cartesian-to-polar testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench import c2p_pkg::*; ();

  localparam int PHASE_ITEMS = 317;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  c2p_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  c2p_out_t out_data;

  int errors;
  int pending;
  int checked;
  int send_idle_pct;
  int recv_idle_pct;
  int points_sent;
  int leftover;

  cartesian_to_polar dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  c2p_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{x_coord: x, y_coord: y};
    do @(posedge clk); while (in_stall);
    points_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] edge_value();
    case ($urandom_range(5))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  task automatic send_random_point;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        r;
    r = $urandom;
    x = r[31:16];
    y = r[15:0];
    case ($urandom_range(9))
      4: begin
        x = 16'($urandom_range(127)) - 16'sd64;
        y = 16'($urandom_range(127)) - 16'sd64;
      end
      5: begin
        if (r[0]) x = '0;
        else y = '0;
      end
      6: y = x;
      7: y = -x;
      8: begin
        x = edge_value();
        y = edge_value();
      end
      9: begin
        x = {r[31], {3{~r[31]}}, r[27:16]};
        y = {r[15], {3{~r[15]}}, r[11:0]};
      end
      default: ;
    endcase
    send_point(x, y);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 58;
    points_sent   = 0;
    leftover      = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Origin, axes, corners, diagonals and a few small points.
    send_point(16'sd0, 16'sd0);
    send_point(16'sd32767, 16'sd0);
    send_point(-16'sd32768, 16'sd0);
    send_point(-16'sd5, 16'sd0);
    send_point(16'sd0, 16'sd32767);
    send_point(16'sd0, -16'sd32768);
    send_point(16'sd32767, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768);
    send_point(-16'sd32768, 16'sd32767);
    send_point(16'sd32767, -16'sd32768);
    send_point(16'sd1, 16'sd0);
    send_point(-16'sd1, 16'sd0);
    send_point(16'sd0, 16'sd1);
    send_point(16'sd0, -16'sd1);
    send_point(16'sd1, 16'sd1);
    send_point(-16'sd1, -16'sd1);
    send_point(16'sd1, -16'sd1);
    send_point(-16'sd1, 16'sd1);
    send_point(16'sd100, -16'sd100);
    send_point(-16'sd100, 16'sd100);
    send_point(16'sd3, 16'sd4);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 58 : 0;
      recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 17 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_point();
      end
      drain();
    end

    for (int n = 0; n < 20000 && pending != 0; n++) begin
      @(posedge clk);
    end
    if (pending != 0) begin
      $error("%0d results never arrived", pending);
      leftover = pending;
    end
    repeat (30) @(posedge clk);

    $display("Sent %0d points (origin, axes, corners, diagonals, random) under three",
             points_sent);
    $display("idling patterns; %0d results were checked.", checked);
    if (errors == 0 && leftover == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
